// ===== hw/rtl/caf2d_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package caf2d_pkg;

    localparam int COORD_W   = 32;
    localparam int FRAC_W    = 16;
    localparam int TRIG_W    = 18;
    localparam int REQ_W     = 3;
    localparam int OPW       = COORD_W + 1;
    localparam int PRODW     = 2 * OPW;
    localparam int ACCW      = PRODW + 2;
    localparam int ROM_DEPTH = 34;
    localparam int PC_W      = $clog2(ROM_DEPTH);

    localparam logic signed [COORD_W-1:0] FIX_ONE  = COORD_W'(64'd1 << FRAC_W);
    localparam logic signed [COORD_W-1:0] FIX_ZERO = '0;

    typedef enum logic [REQ_W-1:0] {
        REQ_IDENT     = 3'd0,
        REQ_TRANSLATE = 3'd1,
        REQ_ROTATE    = 3'd2,
        REQ_SCALE     = 3'd3,
        REQ_VERTEX    = 3'd4
    } req_t;

    typedef enum logic [3:0] {
        A_ONE, A_PX, A_PY, A_SN, A_NSN, A_OMC, A_OMAX, A_OMAY,
        A_M0, A_M1, A_M2, A_M3, A_M4, A_M5
    } asel_t;

    typedef enum logic [3:0] {
        B_C0, B_C1, B_C2, B_C3, B_C4, B_C5, B_PX, B_PY, B_ONE
    } bsel_t;

    typedef enum logic [3:0] {
        D_NONE, D_T0, D_T1, D_T2, D_T3, D_T4, D_T5, D_M2, D_M5, D_OX, D_OY
    } dst_t;

    typedef enum logic [1:0] {
        OP_NONE, OP_IDENT, OP_COMMIT, OP_EMIT
    } op_t;

    typedef enum logic [1:0] {
        SEQ_NEXT, SEQ_JUMP, SEQ_END, SEQ_WAIT_OUT
    } seq_t;

    typedef struct packed {
        asel_t            a_sel;
        bsel_t            b_sel;
        logic             first;
        dst_t             dst;
        op_t              op;
        seq_t             seq;
        logic [PC_W-1:0]  target;
    } cw_t;

    typedef struct packed {
        logic out_free;
    } st_t;

    localparam logic [PC_W-1:0] ADDR_IDENT   = PC_W'(0);
    localparam logic [PC_W-1:0] ADDR_NOP_END = PC_W'(1);
    localparam logic [PC_W-1:0] ADDR_ROTATE  = PC_W'(2);
    localparam logic [PC_W-1:0] ADDR_SCALE   = PC_W'(6);
    localparam logic [PC_W-1:0] ADDR_PREMUL  = PC_W'(8);
    localparam logic [PC_W-1:0] ADDR_VERTEX  = PC_W'(25);

    function automatic cw_t cw(asel_t a, bsel_t b, logic f, dst_t d, op_t o, seq_t s,
                               logic [PC_W-1:0] t);
        cw_t w;
        w.a_sel  = a;
        w.b_sel  = b;
        w.first  = f;
        w.dst    = d;
        w.op     = o;
        w.seq    = s;
        w.target = t;
        return w;
    endfunction

    localparam cw_t UCODE [ROM_DEPTH] = '{
        // identity, unused selector
        cw(A_ONE,  B_ONE, 1'b0, D_NONE, OP_IDENT,  SEQ_END,      '0),
        cw(A_ONE,  B_ONE, 1'b0, D_NONE, OP_NONE,   SEQ_END,      '0),
        // rotate: translation terms of the elementary matrix
        cw(A_OMC,  B_PX,  1'b1, D_NONE, OP_NONE,   SEQ_NEXT,     '0),
        cw(A_SN,   B_PY,  1'b0, D_M2,   OP_NONE,   SEQ_NEXT,     '0),
        cw(A_OMC,  B_PY,  1'b1, D_NONE, OP_NONE,   SEQ_NEXT,     '0),
        cw(A_NSN,  B_PX,  1'b0, D_M5,   OP_NONE,   SEQ_JUMP,     ADDR_PREMUL),
        // scale: translation terms of the elementary matrix
        cw(A_OMAX, B_PX,  1'b1, D_M2,   OP_NONE,   SEQ_NEXT,     '0),
        cw(A_OMAY, B_PY,  1'b1, D_M5,   OP_NONE,   SEQ_JUMP,     ADDR_PREMUL),
        // premultiply M * C
        cw(A_M0,   B_C0,  1'b1, D_NONE, OP_NONE,   SEQ_NEXT,     '0),
        cw(A_M1,   B_C3,  1'b0, D_T0,   OP_NONE,   SEQ_NEXT,     '0),
        cw(A_M0,   B_C1,  1'b1, D_NONE, OP_NONE,   SEQ_NEXT,     '0),
        cw(A_M1,   B_C4,  1'b0, D_T1,   OP_NONE,   SEQ_NEXT,     '0),
        cw(A_M0,   B_C2,  1'b1, D_NONE, OP_NONE,   SEQ_NEXT,     '0),
        cw(A_M1,   B_C5,  1'b0, D_NONE, OP_NONE,   SEQ_NEXT,     '0),
        cw(A_M2,   B_ONE, 1'b0, D_T2,   OP_NONE,   SEQ_NEXT,     '0),
        cw(A_M3,   B_C0,  1'b1, D_NONE, OP_NONE,   SEQ_NEXT,     '0),
        cw(A_M4,   B_C3,  1'b0, D_T3,   OP_NONE,   SEQ_NEXT,     '0),
        cw(A_M3,   B_C1,  1'b1, D_NONE, OP_NONE,   SEQ_NEXT,     '0),
        cw(A_M4,   B_C4,  1'b0, D_T4,   OP_NONE,   SEQ_NEXT,     '0),
        cw(A_M3,   B_C2,  1'b1, D_NONE, OP_NONE,   SEQ_NEXT,     '0),
        cw(A_M4,   B_C5,  1'b0, D_NONE, OP_NONE,   SEQ_NEXT,     '0),
        cw(A_M5,   B_ONE, 1'b0, D_T5,   OP_NONE,   SEQ_NEXT,     '0),
        cw(A_ONE,  B_ONE, 1'b0, D_NONE, OP_NONE,   SEQ_NEXT,     '0),
        cw(A_ONE,  B_ONE, 1'b0, D_NONE, OP_NONE,   SEQ_NEXT,     '0),
        cw(A_ONE,  B_ONE, 1'b0, D_NONE, OP_COMMIT, SEQ_END,      '0),
        // transform vertex
        cw(A_PX,   B_C0,  1'b1, D_NONE, OP_NONE,   SEQ_NEXT,     '0),
        cw(A_PY,   B_C1,  1'b0, D_NONE, OP_NONE,   SEQ_NEXT,     '0),
        cw(A_ONE,  B_C2,  1'b0, D_OX,   OP_NONE,   SEQ_NEXT,     '0),
        cw(A_PX,   B_C3,  1'b1, D_NONE, OP_NONE,   SEQ_NEXT,     '0),
        cw(A_PY,   B_C4,  1'b0, D_NONE, OP_NONE,   SEQ_NEXT,     '0),
        cw(A_ONE,  B_C5,  1'b0, D_OY,   OP_NONE,   SEQ_NEXT,     '0),
        cw(A_ONE,  B_ONE, 1'b0, D_NONE, OP_NONE,   SEQ_NEXT,     '0),
        cw(A_ONE,  B_ONE, 1'b0, D_NONE, OP_NONE,   SEQ_NEXT,     '0),
        cw(A_ONE,  B_ONE, 1'b0, D_NONE, OP_EMIT,   SEQ_WAIT_OUT, '0)
    };

    function automatic logic [PC_W-1:0] entry_of(logic [REQ_W-1:0] t);
        logic [PC_W-1:0] a;
        unique case (t)
            REQ_IDENT:     a = ADDR_IDENT;
            REQ_TRANSLATE: a = ADDR_PREMUL;
            REQ_ROTATE:    a = ADDR_ROTATE;
            REQ_SCALE:     a = ADDR_SCALE;
            REQ_VERTEX:    a = ADDR_VERTEX;
            default:       a = ADDR_NOP_END;
        endcase
        return a;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/caf2d_req_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface caf2d_req_if
    import caf2d_pkg::*;
;
    logic                        valid;
    logic                        ready;
    logic [REQ_W-1:0]            req_type;
    logic signed [COORD_W-1:0]   arg_x;
    logic signed [COORD_W-1:0]   arg_y;
    logic signed [TRIG_W-1:0]    cos_term;
    logic signed [TRIG_W-1:0]    sin_term;
    logic signed [COORD_W-1:0]   point_x;
    logic signed [COORD_W-1:0]   point_y;
    logic                        last_in;

    modport source (
        output valid, req_type, arg_x, arg_y, cos_term, sin_term, point_x, point_y,
               last_in,
        input  ready
    );

    modport sink (
        input  valid, req_type, arg_x, arg_y, cos_term, sin_term, point_x, point_y,
               last_in,
        output ready
    );
endinterface

`default_nettype wire

// ===== hw/rtl/caf2d_res_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface caf2d_res_if
    import caf2d_pkg::*;
;
    logic                        valid;
    logic                        ready;
    logic signed [COORD_W-1:0]   out_x;
    logic signed [COORD_W-1:0]   out_y;
    logic                        last_out;

    modport source (
        output valid, out_x, out_y, last_out,
        input  ready
    );

    modport sink (
        input  valid, out_x, out_y, last_out,
        output ready
    );
endinterface

`default_nettype wire

// ===== hw/rtl/caf2d_seq.sv =====
`timescale 1ns / 1ps
`default_nettype none

module caf2d_seq
    import caf2d_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic [REQ_W-1:0] req_type,
    input  wire st_t              status,
    output cw_t                   ctl
);

    logic            busy_reg, busy_next;
    logic [PC_W-1:0] pc_reg, pc_next;
    logic            accept;
    cw_t             word;

    assign in_ready = !busy_reg;
    assign accept   = in_valid && in_ready;
    assign word     = UCODE[pc_reg];

    always_comb
    begin
        ctl = word;
        if (!busy_reg)
        begin
            ctl.op  = OP_NONE;
            ctl.dst = D_NONE;
        end
    end

    always_comb
    begin
        busy_next = busy_reg;
        pc_next   = pc_reg;
        if (accept)
        begin
            busy_next = 1'b1;
            pc_next   = entry_of(req_type);
        end
        else if (busy_reg)
        begin
            unique case (word.seq)
                SEQ_NEXT: pc_next = pc_reg + PC_W'(1);
                SEQ_JUMP: pc_next = word.target;
                SEQ_END:  busy_next = 1'b0;
                SEQ_WAIT_OUT:
                begin
                    if (status.out_free)
                    begin
                        busy_next = 1'b0;
                    end
                end
                default:  busy_next = 1'b0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            pc_reg   <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            pc_reg   <= pc_next;
        end
    end

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy_reg)
        else $error("sequencer did not start after a beat");

    a_end_stops: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && word.seq == SEQ_END |=> !busy_reg)
        else $error("sequencer ran past an end step");

    a_pc_in_rom: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> pc_reg < PC_W'(ROM_DEPTH))
        else $error("step counter left the control store");

endmodule

`default_nettype wire

// ===== hw/rtl/caf2d_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none

module caf2d_dp
    import caf2d_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      accept,
    input  wire logic [REQ_W-1:0]          req_type,
    input  wire logic signed [COORD_W-1:0] arg_x,
    input  wire logic signed [COORD_W-1:0] arg_y,
    input  wire logic signed [TRIG_W-1:0]  cos_term,
    input  wire logic signed [TRIG_W-1:0]  sin_term,
    input  wire logic signed [COORD_W-1:0] point_x,
    input  wire logic signed [COORD_W-1:0] point_y,
    input  wire logic                      last_in,
    input  wire cw_t                       ctl,
    output st_t                            status,
    output logic                           out_valid,
    input  wire logic                      out_ready,
    output logic signed [COORD_W-1:0]     out_x,
    output logic signed [COORD_W-1:0]     out_y,
    output logic                           last_out
);

    localparam logic signed [OPW-1:0] OP_ONE = {{(OPW-COORD_W){1'b0}}, FIX_ONE};
    localparam logic signed [OPW-1:0] OP_ZERO = '0;
    localparam logic signed [ACCW-1:0] HALF = ACCW'(1) << (FRAC_W - 1);
    localparam logic signed [ACCW-1:0] SAT_HI =
        {{(ACCW-COORD_W+1){1'b0}}, {(COORD_W-1){1'b1}}};
    localparam logic signed [ACCW-1:0] SAT_LO =
        {{(ACCW-COORD_W+1){1'b1}}, {(COORD_W-1){1'b0}}};

    logic [REQ_W-1:0]        kind_reg;
    logic signed [OPW-1:0]   ax_reg, ay_reg, sn_reg, nsn_reg, cs_reg;
    logic signed [OPW-1:0]   omc_reg, omax_reg, omay_reg, px_reg, py_reg;
    logic                    last_reg;

    logic signed [COORD_W-1:0] c_reg [6];
    logic signed [COORD_W-1:0] t_reg [6];
    logic signed [COORD_W-1:0] m2_reg, m5_reg, ox_reg, oy_reg;

    logic signed [OPW-1:0]   m0, m1, m2, m3, m4, m5;
    logic signed [OPW-1:0]   op_a, op_b;
    logic signed [PRODW-1:0] prod_reg, prod_next;
    logic signed [ACCW-1:0]  acc_reg, acc_next, prod_ext, rnd, shifted;
    logic signed [COORD_W-1:0] fix_val;
    logic                    first_1;
    dst_t                    dst_1, dst_2;

    logic                    out_valid_reg, out_valid_next;
    logic signed [COORD_W-1:0] out_x_reg, out_y_reg;
    logic                    last_out_reg;
    logic                    out_free, emit;

    function automatic logic signed [OPW-1:0] ext_c(logic signed [COORD_W-1:0] v);
        return {{(OPW-COORD_W){v[COORD_W-1]}}, v};
    endfunction

    function automatic logic signed [OPW-1:0] ext_t(logic signed [TRIG_W-1:0] v);
        return {{(OPW-TRIG_W){v[TRIG_W-1]}}, v};
    endfunction

    // latch operands at the accepted beat
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg <= req_type;
            ax_reg   <= ext_c(arg_x);
            ay_reg   <= ext_c(arg_y);
            cs_reg   <= ext_t(cos_term);
            sn_reg   <= ext_t(sin_term);
            nsn_reg  <= OP_ZERO - ext_t(sin_term);
            omc_reg  <= OP_ONE - ext_t(cos_term);
            omax_reg <= OP_ONE - ext_c(arg_x);
            omay_reg <= OP_ONE - ext_c(arg_y);
            px_reg   <= ext_c(point_x);
            py_reg   <= ext_c(point_y);
            last_reg <= last_in;
        end
    end

    always_comb
    begin
        unique case (kind_reg)
            REQ_TRANSLATE:
            begin
                m0 = OP_ONE;  m1 = OP_ZERO; m2 = ax_reg;
                m3 = OP_ZERO; m4 = OP_ONE;  m5 = ay_reg;
            end
            REQ_ROTATE:
            begin
                m0 = cs_reg;  m1 = nsn_reg; m2 = ext_c(m2_reg);
                m3 = sn_reg;  m4 = cs_reg;  m5 = ext_c(m5_reg);
            end
            default:
            begin
                m0 = ax_reg;  m1 = OP_ZERO; m2 = ext_c(m2_reg);
                m3 = OP_ZERO; m4 = ay_reg;  m5 = ext_c(m5_reg);
            end
        endcase
    end

    always_comb
    begin
        unique case (ctl.a_sel)
            A_ONE:   op_a = OP_ONE;
            A_PX:    op_a = px_reg;
            A_PY:    op_a = py_reg;
            A_SN:    op_a = sn_reg;
            A_NSN:   op_a = nsn_reg;
            A_OMC:   op_a = omc_reg;
            A_OMAX:  op_a = omax_reg;
            A_OMAY:  op_a = omay_reg;
            A_M0:    op_a = m0;
            A_M1:    op_a = m1;
            A_M2:    op_a = m2;
            A_M3:    op_a = m3;
            A_M4:    op_a = m4;
            A_M5:    op_a = m5;
            default: op_a = OP_ZERO;
        endcase
    end

    always_comb
    begin
        unique case (ctl.b_sel)
            B_C0:    op_b = ext_c(c_reg[0]);
            B_C1:    op_b = ext_c(c_reg[1]);
            B_C2:    op_b = ext_c(c_reg[2]);
            B_C3:    op_b = ext_c(c_reg[3]);
            B_C4:    op_b = ext_c(c_reg[4]);
            B_C5:    op_b = ext_c(c_reg[5]);
            B_PX:    op_b = px_reg;
            B_PY:    op_b = py_reg;
            B_ONE:   op_b = OP_ONE;
            default: op_b = OP_ZERO;
        endcase
    end

    assign prod_next = op_a * op_b;
    assign prod_ext  = {{(ACCW-PRODW){prod_reg[PRODW-1]}}, prod_reg};
    assign acc_next  = first_1 ? prod_ext : acc_reg + prod_ext;

    // round half up, then saturate
    assign rnd     = acc_reg + HALF;
    assign shifted = rnd >>> FRAC_W;
    always_comb
    begin
        if (shifted > SAT_HI)
        begin
            fix_val = SAT_HI[COORD_W-1:0];
        end
        else if (shifted < SAT_LO)
        begin
            fix_val = SAT_LO[COORD_W-1:0];
        end
        else
        begin
            fix_val = shifted[COORD_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_1 <= 1'b0;
            dst_1   <= D_NONE;
            dst_2   <= D_NONE;
        end
        else
        begin
            first_1 <= ctl.first;
            dst_1   <= ctl.dst;
            dst_2   <= dst_1;
        end
    end

    always_ff @(posedge clk)
    begin
        case (dst_2)
            D_T0:    t_reg[0] <= fix_val;
            D_T1:    t_reg[1] <= fix_val;
            D_T2:    t_reg[2] <= fix_val;
            D_T3:    t_reg[3] <= fix_val;
            D_T4:    t_reg[4] <= fix_val;
            D_T5:    t_reg[5] <= fix_val;
            D_M2:    m2_reg   <= fix_val;
            D_M5:    m5_reg   <= fix_val;
            D_OX:    ox_reg   <= fix_val;
            D_OY:    oy_reg   <= fix_val;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_reg[0] <= FIX_ONE;
            c_reg[1] <= FIX_ZERO;
            c_reg[2] <= FIX_ZERO;
            c_reg[3] <= FIX_ZERO;
            c_reg[4] <= FIX_ONE;
            c_reg[5] <= FIX_ZERO;
        end
        else if (ctl.op == OP_IDENT)
        begin
            c_reg[0] <= FIX_ONE;
            c_reg[1] <= FIX_ZERO;
            c_reg[2] <= FIX_ZERO;
            c_reg[3] <= FIX_ZERO;
            c_reg[4] <= FIX_ONE;
            c_reg[5] <= FIX_ZERO;
        end
        else if (ctl.op == OP_COMMIT)
        begin
            c_reg <= t_reg;
        end
    end

    // output slot: hold while stalled, load on emit
    assign out_free        = !out_valid_reg || out_ready;
    assign emit            = (ctl.op == OP_EMIT) && out_free;
    assign status.out_free = out_free;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_x_reg    <= ox_reg;
            out_y_reg    <= oy_reg;
            last_out_reg <= last_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_x     = out_x_reg;
    assign out_y     = out_y_reg;
    assign last_out  = last_out_reg;

    a_emit_loads: assert property (@(posedge clk) disable iff (!rst_n)
        emit |=> out_valid_reg)
        else $error("emit step did not present a beat");

    a_commit_drained: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.op == OP_COMMIT |-> dst_1 == D_NONE && dst_2 == D_NONE)
        else $error("commit while a product is still in flight");

    a_emit_drained: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.op == OP_EMIT |-> dst_1 == D_NONE && dst_2 == D_NONE)
        else $error("emit while a vertex term is still in flight");

endmodule

`default_nettype wire

// ===== hw/rtl/composite_affine_2d_transform.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Work per item, set by the shared multiply-accumulate unit stepped by the control store:
//   identity or unused 1, translate 17, scale 19, rotate 21, vertex 9 steps (9+ under stall).
// Handshake: ready stays low while a sequence runs; it rises the cycle after the last step.
// Reset: asynchronous, active low; composite returns to identity, sequencer and output idle.
module composite_affine_2d_transform
    import caf2d_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    caf2d_req_if.sink    req,
    caf2d_res_if.source  res
);

    cw_t  ctl;
    st_t  status;
    logic accept;

    assign accept = req.valid && req.ready;

    caf2d_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (req.ready),
        .req_type (req.req_type),
        .status   (status),
        .ctl      (ctl)
    );

    caf2d_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .req_type  (req.req_type),
        .arg_x     (req.arg_x),
        .arg_y     (req.arg_y),
        .cos_term  (req.cos_term),
        .sin_term  (req.sin_term),
        .point_x   (req.point_x),
        .point_y   (req.point_y),
        .last_in   (req.last_in),
        .ctl       (ctl),
        .status    (status),
        .out_valid (res.valid),
        .out_ready (res.ready),
        .out_x     (res.out_x),
        .out_y     (res.out_y),
        .last_out  (res.last_out)
    );

endmodule

`default_nettype wire
